// ===== rtl/dett_pkg.sv =====
`timescale 1ns / 1ps
package dett_pkg;

	localparam int SLOTS       = 64;
	localparam int MAX_RESULTS = 64;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int WORD_W      = 32;

	// request kinds
	localparam logic [1:0] K_SCHEDULE = 2'd0;
	localparam logic [1:0] K_REMOVE   = 2'd1;
	localparam logic [1:0] K_ELAPSE   = 2'd2;

	// result kinds
	localparam logic [1:0] RK_DISPATCH    = 2'd0;
	localparam logic [1:0] RK_SCHED_DONE  = 2'd1;
	localparam logic [1:0] RK_REMOVE_DONE = 2'd2;
	localparam logic [1:0] RK_ELAPSE_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] event_id;
		logic [WORD_W-1:0] event_arg;
		logic [WORD_W-1:0] debug_tag;
		logic [WORD_W-1:0] tick_count;
	} req_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [WORD_W-1:0] fired_id;
		logic [WORD_W-1:0] fired_arg;
		logic [WORD_W-1:0] fired_tag;
		logic              table_full;
		logic              removed_any;
		logic [WORD_W-1:0] min_remaining;
		logic              next_valid;
		logic              last;
	} res_t;

	// stored event words, written together on schedule
	typedef struct packed {
		logic [WORD_W-1:0] id;
		logic [WORD_W-1:0] arg;
		logic [WORD_W-1:0] tag;
	} rec_t;

	// sequencer to slot store
	typedef struct packed {
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] sel_idx;
		logic             rec_we;
		logic             rem_we;
		logic             occ_set;
		logic             occ_clr;
		logic             due_set;
		logic             due_clr;
	} store_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCHED,
		ST_SCAN,
		ST_FIRE_SEEK,
		ST_FIRE_LOAD,
		ST_RESP
	} state_t;

endpackage

// ===== rtl/dett_store.sv =====
`timescale 1ns / 1ps
module dett_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dett_pkg::store_ctl_t          ctl,
	input  dett_pkg::rec_t                wr_rec,
	input  logic [dett_pkg::WORD_W-1:0]   wr_rem,
	output dett_pkg::rec_t                rd_rec,
	output logic [dett_pkg::WORD_W-1:0]   rd_rem,
	output logic                          occ_bit,
	output logic                          due_bit,
	output logic                          due_any
);

	dett_pkg::rec_t                rec_mem [dett_pkg::SLOTS];
	logic [dett_pkg::WORD_W-1:0]   rem_mem [dett_pkg::SLOTS];
	dett_pkg::rec_t                rd_rec_q;
	logic [dett_pkg::WORD_W-1:0]   rd_rem_q;
	logic [dett_pkg::SLOTS-1:0]    occ_q;
	logic [dett_pkg::SLOTS-1:0]    due_q;

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (ctl.rec_we) begin
			rec_mem[ctl.sel_idx] <= wr_rec;
		end
		if (ctl.rem_we) begin
			rem_mem[ctl.sel_idx] <= wr_rem;
		end
		rd_rec_q <= rec_mem[ctl.rd_idx];
		rd_rem_q <= rem_mem[ctl.rd_idx];
	end

	// occupied: stored id nonzero; due: fired by the running elapse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			due_q <= '0;
		end else begin
			if (ctl.occ_set) begin
				occ_q[ctl.sel_idx] <= 1'b1;
			end else if (ctl.occ_clr) begin
				occ_q[ctl.sel_idx] <= 1'b0;
			end
			if (ctl.due_set) begin
				due_q[ctl.sel_idx] <= 1'b1;
			end else if (ctl.due_clr) begin
				due_q[ctl.sel_idx] <= 1'b0;
			end
		end
	end

	assign rd_rec  = rd_rec_q;
	assign rd_rem  = rd_rem_q;
	assign occ_bit = occ_q[ctl.sel_idx];
	assign due_bit = due_q[ctl.sel_idx];
	assign due_any = |due_q;

endmodule

// ===== rtl/dett_alu.sv =====
`timescale 1ns / 1ps
module dett_alu (
	input  logic [dett_pkg::WORD_W-1:0] a,
	input  logic [dett_pkg::WORD_W-1:0] b,
	input  logic [dett_pkg::WORD_W-1:0] best,
	output logic                        eq,
	output logic [dett_pkg::WORD_W-1:0] sat,
	output logic                        sat_zero,
	output logic                        lt_best
);

	logic [dett_pkg::WORD_W:0] diff;
	logic                      borrow;
	logic                      diff_zero;

	// one subtractor serves id match and saturating tick count
	assign diff      = {1'b0, a} - {1'b0, b};
	assign borrow    = diff[dett_pkg::WORD_W];
	assign diff_zero = (diff[dett_pkg::WORD_W-1:0] == '0);
	assign eq        = !borrow && diff_zero;
	assign sat_zero  = borrow || diff_zero;
	assign sat       = borrow ? '0 : diff[dett_pkg::WORD_W-1:0];
	assign lt_best   = (sat < best);

endmodule

// ===== rtl/delayed_event_timer_table.sv =====
`timescale 1ns / 1ps
// Immediate dispatch goes straight to the result; schedule walks the table for the lowest free
// slot; remove and elapse scan every slot, one slot per cycle through the shared subtractor;
// an elapse then seeks each fired event and loads it, skipping the slots that are not due.
// One request at a time: the next one is taken in idle, once the final result has registered;
// a stalled result stalls the seq.
// Reset: async active low; all slots free and no request in flight, no clearing pass.
module delayed_event_timer_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dett_pkg::req_t  req,
	output logic            res_valid,
	input  logic            res_ready,
	output dett_pkg::res_t  res
);

	dett_pkg::state_t                 state_q, state_d;
	dett_pkg::req_t                   req_q, req_d;
	logic [dett_pkg::CNT_W-1:0]       idx_q, idx_d;
	logic                             v_s1, v_s1_d;
	logic [dett_pkg::IDX_W-1:0]       idx_s1, idx_s1_d;
	logic [dett_pkg::FCNT_W-1:0]      fcnt_q, fcnt_d;
	logic [dett_pkg::FCNT_W-1:0]      em_q, em_d;
	logic                             removed_q, removed_d;
	logic                             full_q, full_d;
	logic [dett_pkg::WORD_W-1:0]      nd_q, nd_d;
	logic                             nv_q, nv_d;
	logic [1:0]                       rk_q, rk_d;
	dett_pkg::res_t                   res_q, res_d;
	logic                             res_valid_q, res_valid_d;

	dett_pkg::store_ctl_t             ctl;
	dett_pkg::rec_t                   wr_rec;
	logic [dett_pkg::WORD_W-1:0]      wr_rem;
	dett_pkg::rec_t                   rd_rec;
	logic [dett_pkg::WORD_W-1:0]      rd_rem;
	logic                             occ_bit;
	logic                             due_bit;
	logic                             due_any;

	logic [dett_pkg::WORD_W-1:0]      alu_a;
	logic [dett_pkg::WORD_W-1:0]      alu_b;
	logic                             alu_eq;
	logic [dett_pkg::WORD_W-1:0]      alu_sat;
	logic                             alu_sat_zero;
	logic                             alu_lt;

	logic                             out_free;
	logic                             is_remove;
	logic                             scan_end;
	logic                             fire_last;

	dett_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.wr_rec  (wr_rec),
		.wr_rem  (wr_rem),
		.rd_rec  (rd_rec),
		.rd_rem  (rd_rem),
		.occ_bit (occ_bit),
		.due_bit (due_bit),
		.due_any (due_any)
	);

	// remove compares stored id with the request id; elapse counts down the slot
	assign is_remove = (req_q.kind == dett_pkg::K_REMOVE);
	assign alu_a     = is_remove ? rd_rec.id : rd_rem;
	assign alu_b     = is_remove ? req_q.event_id : req_q.tick_count;

	dett_alu u_alu (
		.a        (alu_a),
		.b        (alu_b),
		.best     (nd_q),
		.eq       (alu_eq),
		.sat      (alu_sat),
		.sat_zero (alu_sat_zero),
		.lt_best  (alu_lt)
	);

	assign out_free  = !res_valid_q || res_ready;
	assign scan_end  = (idx_q == dett_pkg::CNT_W'(dett_pkg::SLOTS)) && !v_s1;
	assign fire_last = (dett_pkg::FCNT_W'(em_q + 1'b1) == fcnt_q);

	assign wr_rec.id  = req_q.event_id;
	assign wr_rec.arg = req_q.event_arg;
	assign wr_rec.tag = req_q.debug_tag;
	assign wr_rem     = (state_q == dett_pkg::ST_SCAN) ? alu_sat : req_q.tick_count;

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		idx_d       = idx_q;
		v_s1_d      = 1'b0;
		idx_s1_d    = idx_q[dett_pkg::IDX_W-1:0];
		fcnt_d      = fcnt_q;
		em_d        = em_q;
		removed_d   = removed_q;
		full_d      = full_q;
		nd_d        = nd_q;
		nv_d        = nv_q;
		rk_d        = rk_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		req_ready   = 1'b0;

		ctl         = '0;
		ctl.rd_idx  = idx_q[dett_pkg::IDX_W-1:0];
		ctl.sel_idx = idx_q[dett_pkg::IDX_W-1:0];

		case (state_q)
			dett_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_d     = req;
					idx_d     = '0;
					removed_d = 1'b0;
					full_d    = 1'b0;
					nd_d      = '0;
					nv_d      = 1'b0;
					fcnt_d    = '0;
					em_d      = '0;
					case (req.kind)
						dett_pkg::K_SCHEDULE: begin
							if (req.tick_count[dett_pkg::WORD_W-1:1] == '0) begin
								rk_d    = dett_pkg::RK_DISPATCH;
								state_d = dett_pkg::ST_RESP;
							end else begin
								state_d = dett_pkg::ST_SCHED;
							end
						end
						dett_pkg::K_REMOVE, dett_pkg::K_ELAPSE: begin
							state_d = dett_pkg::ST_SCAN;
						end
						default: begin
							state_d = dett_pkg::ST_IDLE;
						end
					endcase
				end
			end

			// walk the occupied bits for the lowest free slot
			dett_pkg::ST_SCHED: begin
				if (idx_q == dett_pkg::CNT_W'(dett_pkg::SLOTS)) begin
					full_d  = 1'b1;
					rk_d    = dett_pkg::RK_SCHED_DONE;
					state_d = dett_pkg::ST_RESP;
				end else if (!occ_bit) begin
					ctl.rec_we  = 1'b1;
					ctl.rem_we  = 1'b1;
					ctl.occ_set = (req_q.event_id != '0);
					rk_d        = dett_pkg::RK_SCHED_DONE;
					state_d     = dett_pkg::ST_RESP;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end

			// read slot idx_q; the registered read is evaluated as slot idx_s1 in the next cycle
			dett_pkg::ST_SCAN: begin
				ctl.sel_idx = idx_s1;
				if (idx_q != dett_pkg::CNT_W'(dett_pkg::SLOTS)) begin
					v_s1_d = 1'b1;
					idx_d  = idx_q + 1'b1;
				end
				if (v_s1 && occ_bit) begin
					if (is_remove) begin
						if (alu_eq) begin
							ctl.occ_clr = 1'b1;
							removed_d   = 1'b1;
						end
					end else begin
						ctl.rem_we = 1'b1;
						if (alu_sat_zero &&
						    (fcnt_q < dett_pkg::FCNT_W'(dett_pkg::MAX_RESULTS))) begin
							ctl.occ_clr = 1'b1;
							ctl.due_set = 1'b1;
							fcnt_d      = fcnt_q + 1'b1;
						end else if (!nv_q || alu_lt) begin
							nd_d = alu_sat;
							nv_d = 1'b1;
						end
					end
				end
				if (scan_end) begin
					if (is_remove) begin
						rk_d    = dett_pkg::RK_REMOVE_DONE;
						state_d = dett_pkg::ST_RESP;
					end else if (fcnt_q == '0) begin
						rk_d    = dett_pkg::RK_ELAPSE_NONE;
						state_d = dett_pkg::ST_RESP;
					end else begin
						idx_d   = '0;
						state_d = dett_pkg::ST_FIRE_SEEK;
					end
				end
			end

			dett_pkg::ST_FIRE_SEEK: begin
				if (due_bit) begin
					state_d = dett_pkg::ST_FIRE_LOAD;
				end else if (idx_q != dett_pkg::CNT_W'(dett_pkg::SLOTS)) begin
					idx_d = idx_q + 1'b1;
				end
			end

			// read address still idx_q, so rd_rec holds while the output stalls
			dett_pkg::ST_FIRE_LOAD: begin
				if (out_free) begin
					res_d             = '0;
					res_d.result_kind = dett_pkg::RK_DISPATCH;
					res_d.fired_id    = rd_rec.id;
					res_d.fired_arg   = rd_rec.arg;
					res_d.fired_tag   = rd_rec.tag;
					res_d.last        = fire_last;
					if (fire_last) begin
						res_d.min_remaining = nd_q;
						res_d.next_valid    = nv_q;
						state_d             = dett_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = dett_pkg::ST_FIRE_SEEK;
					end
					res_valid_d = 1'b1;
					ctl.due_clr = 1'b1;
					em_d        = em_q + 1'b1;
				end
			end

			dett_pkg::ST_RESP: begin
				if (out_free) begin
					res_d             = '0;
					res_d.result_kind = rk_q;
					res_d.last        = 1'b1;
					case (rk_q)
						dett_pkg::RK_DISPATCH: begin
							res_d.fired_id  = req_q.event_id;
							res_d.fired_arg = req_q.event_arg;
							res_d.fired_tag = req_q.debug_tag;
						end
						dett_pkg::RK_SCHED_DONE: begin
							res_d.table_full = full_q;
						end
						dett_pkg::RK_REMOVE_DONE: begin
							res_d.removed_any = removed_q;
						end
						default: begin
							res_d.min_remaining = nd_q;
							res_d.next_valid    = nv_q;
						end
					endcase
					res_valid_d = 1'b1;
					state_d     = dett_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = dett_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dett_pkg::ST_IDLE;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
			fcnt_q      <= '0;
			em_q        <= '0;
		end else begin
			state_q     <= state_d;
			v_s1        <= v_s1_d;
			res_valid_q <= res_valid_d;
			fcnt_q      <= fcnt_d;
			em_q        <= em_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q     <= req_d;
		idx_q     <= idx_d;
		idx_s1    <= idx_s1_d;
		removed_q <= removed_d;
		full_q    <= full_d;
		nd_q      <= nd_d;
		nv_q      <= nv_d;
		rk_q      <= rk_d;
		res_q     <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// due slots exist only while an elapse request fires them
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dett_pkg::ST_IDLE) |-> !due_any)
		else $error("due slot left after elapse");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dett_pkg::ST_FIRE_SEEK) |-> due_any)
		else $error("seeking with no due slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(em_q <= fcnt_q) && (fcnt_q <= dett_pkg::FCNT_W'(dett_pkg::MAX_RESULTS)))
		else $error("fire count out of range");

	// a result without last only comes from the fire sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.last) |->
		(res_q.result_kind == dett_pkg::RK_DISPATCH) &&
		((state_q == dett_pkg::ST_FIRE_SEEK) || (state_q == dett_pkg::ST_FIRE_LOAD)))
		else $error("non-final result outside elapse");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.table_full) |->
		(res_q.result_kind == dett_pkg::RK_SCHED_DONE))
		else $error("full flag on wrong result kind");
`endif

endmodule
